[design/pcorr_pkg.sv]
// Shared types and constants for the Pearson correlation unit.
// No dependencies; used by pcorr_ctrl, pcorr_dp and pearson_correlation_unit.
package pcorr_pkg;

   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned COUNT_W  = 13;
   localparam int unsigned SUM_W    = 28;
   localparam int unsigned SQ_W     = 43;
   localparam int unsigned PROD_W   = 64;
   localparam int unsigned BIG_W    = 110;  // vx*vy and num^2
   localparam int unsigned ROOT_W   = 141;  // root search accumulators
   localparam int unsigned Q_W      = 15;   // |r| in Q1.14, up to 16384
   localparam int unsigned BIT_W    = 4;
   localparam logic [COUNT_W-1:0] MAX_LEN  = 13'd4096;
   localparam logic [BIT_W-1:0]   TOP_BIT  = 4'd14;

   typedef enum logic [1:0] {
      RES_OK       = 2'd0,
      RES_SHORT    = 2'd1,
      RES_FLAT     = 2'd2,
      RES_OVERFLOW = 2'd3
   } res_code_type;

   // Wide products, run in this order
   typedef enum logic [2:0] {
      MUL_N_SXY  = 3'd0,
      MUL_SX_SY  = 3'd1,
      MUL_N_SXX  = 3'd2,
      MUL_SX_SX  = 3'd3,
      MUL_N_SYY  = 3'd4,
      MUL_SY_SY  = 3'd5,
      MUL_VX_VY  = 3'd6,
      MUL_NUM_SQ = 3'd7
   } mul_op_type;

   typedef enum logic [2:0] {
      CS_ACCUM,
      CS_MUL_LOAD,
      CS_MUL_WAIT,
      CS_ROOT_INIT,
      CS_ROOT_ADD,
      CS_ROOT_STEP,
      CS_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic             acc_en;
      logic             mul_load;
      mul_op_type       mul_op;
      logic             root_init;
      logic             root_add;
      logic             root_step;
      logic [BIT_W-1:0] root_bit;
      logic             out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic mul_done;
      logic code_ok;
      logic out_free;
   } dp_status_type;

endpackage

[design/pearson_correlation_unit.sv]
// Top level of the Pearson correlation unit: controller plus datapath.
// Depends on pcorr_pkg, pcorr_ctrl, pcorr_dp.
//
//  channel | dir | ports             | content
//  req     | in  | req_t*            | one x/y element pair, tlast closes the vectors
//  rsp     | out | rsp_t*            | r in Q1.14, pair count, status code
//
// Accumulation takes one request per cycle. The last request starts eight
// 64x64 products on one shared 32x32 multiplier and a 15-bit root search,
// during which req_tready is held low.
// Reset is synchronous and clears the sums and the result valid flag.
// The result sits in an output register; accumulation of the next vectors
// resumes while it waits on rsp_tready.
module pearson_correlation_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] sample_x, [31:16] sample_y
   input  logic        req_tlast,   // is_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] correlation, [28:16] pair_count, rest 0
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   pcorr_pkg::dp_cmd_type    cmd;
   pcorr_pkg::dp_status_type status;

   pcorr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pcorr_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_tdata  (req_tdata),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[design/pcorr_ctrl.sv]
// Sequencer for the Pearson correlation unit: accumulate, wide products, root search.
// Depends on pcorr_pkg.
module pcorr_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tlast,
   output logic                     req_tready,
   input  pcorr_pkg::dp_status_type status,
   output pcorr_pkg::dp_cmd_type    cmd
);

   pcorr_pkg::ctrl_state_type       state_ff, state_in;
   pcorr_pkg::mul_op_type           op_ff, op_in;
   logic [pcorr_pkg::BIT_W-1:0]     bit_ff, bit_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pcorr_pkg::CS_ACCUM;
         op_ff    <= pcorr_pkg::MUL_N_SXY;
         bit_ff   <= pcorr_pkg::TOP_BIT;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         bit_ff   <= bit_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      bit_in   = bit_ff;
      unique case (state_ff)
         pcorr_pkg::CS_ACCUM: begin
            if (req_tvalid && req_tlast) begin
               state_in = pcorr_pkg::CS_MUL_LOAD;
               op_in    = pcorr_pkg::MUL_N_SXY;
            end
         end
         pcorr_pkg::CS_MUL_LOAD: state_in = pcorr_pkg::CS_MUL_WAIT;
         pcorr_pkg::CS_MUL_WAIT: begin
            if (status.mul_done) begin
               if (op_ff == pcorr_pkg::MUL_NUM_SQ) begin
                  state_in = status.code_ok ? pcorr_pkg::CS_ROOT_INIT : pcorr_pkg::CS_FINISH;
               end else begin
                  op_in    = pcorr_pkg::mul_op_type'(op_ff + 3'd1);
                  state_in = pcorr_pkg::CS_MUL_LOAD;
               end
            end
         end
         pcorr_pkg::CS_ROOT_INIT: begin
            state_in = pcorr_pkg::CS_ROOT_ADD;
            bit_in   = pcorr_pkg::TOP_BIT;
         end
         pcorr_pkg::CS_ROOT_ADD: state_in = pcorr_pkg::CS_ROOT_STEP;
         pcorr_pkg::CS_ROOT_STEP: begin
            if (bit_ff == '0) begin
               state_in = pcorr_pkg::CS_FINISH;
            end else begin
               bit_in   = bit_ff - 4'd1;
               state_in = pcorr_pkg::CS_ROOT_ADD;
            end
         end
         pcorr_pkg::CS_FINISH: begin
            if (status.out_free) state_in = pcorr_pkg::CS_ACCUM;
         end
         default: state_in = pcorr_pkg::CS_ACCUM;
      endcase
   end

   // outputs
   always_comb begin
      req_tready    = (state_ff == pcorr_pkg::CS_ACCUM);
      cmd.acc_en    = (state_ff == pcorr_pkg::CS_ACCUM) && req_tvalid;
      cmd.mul_load  = (state_ff == pcorr_pkg::CS_MUL_LOAD);
      cmd.mul_op    = op_ff;
      cmd.root_init = (state_ff == pcorr_pkg::CS_ROOT_INIT);
      cmd.root_add  = (state_ff == pcorr_pkg::CS_ROOT_ADD);
      cmd.root_step = (state_ff == pcorr_pkg::CS_ROOT_STEP);
      cmd.root_bit  = bit_ff;
      cmd.out_load  = (state_ff == pcorr_pkg::CS_FINISH) && status.out_free;
   end

endmodule

[design/pcorr_dp.sv]
// Datapath: running sums, 32x32 limb multiplier, bitwise root search, output register.
// Depends on pcorr_pkg.
module pcorr_dp (
   input  logic                     clock,
   input  logic                     reset,
   input  pcorr_pkg::dp_cmd_type    cmd,
   input  logic [31:0]              req_tdata,
   output pcorr_pkg::dp_status_type status,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [31:0]              rsp_tdata,
   output logic [1:0]               rsp_tuser
);

   localparam int unsigned RW = pcorr_pkg::ROOT_W;

   function automatic logic [63:0] mag64(input logic signed [63:0] v);
      mag64 = v[63] ? 64'(-v) : 64'(v);
   endfunction

   // ---- accumulation ----
   logic signed [15:0] x, y;
   logic signed [31:0] xy, xx, yy;
   logic [pcorr_pkg::COUNT_W-1:0]     count_ff;
   logic signed [pcorr_pkg::SUM_W-1:0] sx_ff, sy_ff;
   logic signed [pcorr_pkg::SQ_W-1:0]  sxy_ff, sxx_ff, syy_ff;
   logic                               ovf_ff;

   assign x  = signed'(req_tdata[15:0]);
   assign y  = signed'(req_tdata[31:16]);
   assign xy = x * y;
   assign xx = x * x;
   assign yy = y * y;

   always_ff @(posedge clock) begin
      if (reset || cmd.out_load) begin
         count_ff <= '0;
         sx_ff    <= '0;
         sy_ff    <= '0;
         sxy_ff   <= '0;
         sxx_ff   <= '0;
         syy_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else if (cmd.acc_en) begin
         if (count_ff < pcorr_pkg::MAX_LEN) begin
            count_ff <= count_ff + 13'd1;
            sx_ff    <= sx_ff + 28'(x);
            sy_ff    <= sy_ff + 28'(y);
            sxy_ff   <= sxy_ff + 43'(xy);
            sxx_ff   <= sxx_ff + 43'(xx);
            syy_ff   <= syy_ff + 43'(yy);
         end else begin
            ovf_ff   <= 1'b1;
         end
      end
   end

   // ---- wide products ----
   logic signed [63:0] prod_ff [6];
   logic [pcorr_pkg::BIG_W-1:0] pv_ff, nsq_ff;
   logic signed [63:0] num, vx, vy;
   logic [63:0] opa_in, opb_in, opa_ff, opb_ff;
   logic        sign_in, sign_ff;
   pcorr_pkg::mul_op_type mop_ff;
   logic [2:0]  mstep_ff;
   logic        mbusy_ff, ppv_ff, mul_done;
   logic [1:0]  ppsh_ff;
   logic [63:0] pp_ff;
   logic [127:0] acc_ff, pp_shift;
   logic [63:0] signed_lo;

   assign num = prod_ff[0] - prod_ff[1];
   assign vx  = prod_ff[2] - prod_ff[3];
   assign vy  = prod_ff[4] - prod_ff[5];

   always_comb begin
      opa_in  = 64'(count_ff);
      opb_in  = '0;
      sign_in = 1'b0;
      unique case (cmd.mul_op)
         pcorr_pkg::MUL_N_SXY: begin
            opb_in  = mag64(64'(sxy_ff));
            sign_in = sxy_ff[pcorr_pkg::SQ_W-1];
         end
         pcorr_pkg::MUL_SX_SY: begin
            opa_in  = mag64(64'(sx_ff));
            opb_in  = mag64(64'(sy_ff));
            sign_in = sx_ff[pcorr_pkg::SUM_W-1] ^ sy_ff[pcorr_pkg::SUM_W-1];
         end
         pcorr_pkg::MUL_N_SXX: opb_in = mag64(64'(sxx_ff));
         pcorr_pkg::MUL_SX_SX: begin
            opa_in = mag64(64'(sx_ff));
            opb_in = mag64(64'(sx_ff));
         end
         pcorr_pkg::MUL_N_SYY: opb_in = mag64(64'(syy_ff));
         pcorr_pkg::MUL_SY_SY: begin
            opa_in = mag64(64'(sy_ff));
            opb_in = mag64(64'(sy_ff));
         end
         pcorr_pkg::MUL_VX_VY: begin
            opa_in = 64'(vx);
            opb_in = 64'(vy);
         end
         pcorr_pkg::MUL_NUM_SQ: begin
            opa_in = mag64(num);
            opb_in = mag64(num);
         end
         default: ;
      endcase
   end

   always_comb begin
      case (ppsh_ff)
         2'd0:    pp_shift = {64'b0, pp_ff};
         2'd1:    pp_shift = {32'b0, pp_ff, 32'b0};
         default: pp_shift = {pp_ff, 64'b0};
      endcase
   end

   assign mul_done  = mbusy_ff && (mstep_ff == 3'd5);
   assign signed_lo = sign_ff ? -acc_ff[63:0] : acc_ff[63:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         mbusy_ff <= 1'b0;
         ppv_ff   <= 1'b0;
         mstep_ff <= '0;
      end else if (cmd.mul_load) begin
         mbusy_ff <= 1'b1;
         ppv_ff   <= 1'b0;
         mstep_ff <= '0;
      end else if (mul_done) begin
         mbusy_ff <= 1'b0;
      end else if (mbusy_ff) begin
         mstep_ff <= mstep_ff + 3'd1;
         ppv_ff   <= (mstep_ff < 3'd4);
      end
   end

   // limb i of a times limb j of b, i = step[1], j = step[0]
   always_ff @(posedge clock) begin
      if (cmd.mul_load) begin
         opa_ff  <= opa_in;
         opb_ff  <= opb_in;
         sign_ff <= sign_in;
         mop_ff  <= cmd.mul_op;
         acc_ff  <= '0;
      end else begin
         if (ppv_ff) acc_ff <= acc_ff + pp_shift;
         pp_ff   <= (mstep_ff[1] ? opa_ff[63:32] : opa_ff[31:0]) *
                    (mstep_ff[0] ? opb_ff[63:32] : opb_ff[31:0]);
         ppsh_ff <= {1'b0, mstep_ff[1]} + {1'b0, mstep_ff[0]};
      end
      if (mul_done) begin
         case (mop_ff)
            pcorr_pkg::MUL_N_SXY:  prod_ff[0] <= signed_lo;
            pcorr_pkg::MUL_SX_SY:  prod_ff[1] <= signed_lo;
            pcorr_pkg::MUL_N_SXX:  prod_ff[2] <= signed_lo;
            pcorr_pkg::MUL_SX_SX:  prod_ff[3] <= signed_lo;
            pcorr_pkg::MUL_N_SYY:  prod_ff[4] <= signed_lo;
            pcorr_pkg::MUL_SY_SY:  prod_ff[5] <= signed_lo;
            pcorr_pkg::MUL_VX_VY:  pv_ff  <= acc_ff[pcorr_pkg::BIG_W-1:0];
            default:               nsq_ff <= acc_ff[pcorr_pkg::BIG_W-1:0];
         endcase
      end
   end

   // ---- result code ----
   pcorr_pkg::res_code_type code;
   always_comb begin
      if (ovf_ff)                   code = pcorr_pkg::RES_OVERFLOW;
      else if (count_ff < 13'd2)    code = pcorr_pkg::RES_SHORT;
      else if (vx == 0 || vy == 0)  code = pcorr_pkg::RES_FLAT;
      else                          code = pcorr_pkg::RES_OK;
   end

   // ---- root search: largest q with q^2*P <= num^2*2^28 ----
   // q2p = q^2*P, qps = q*P<<(b+1), ps = P<<2b
   logic [RW-1:0] q2p_ff, qps_ff, ps_ff, part_ff, trial, limit;
   logic [pcorr_pkg::Q_W-1:0] q_ff;
   logic fits;

   assign trial = part_ff + ps_ff;
   assign limit = {3'b0, nsq_ff, 28'b0};
   assign fits  = (trial <= limit) && !q_ff[pcorr_pkg::Q_W-1];

   always_ff @(posedge clock) begin
      if (cmd.root_init) begin
         q2p_ff <= '0;
         qps_ff <= '0;
         ps_ff  <= {3'b0, pv_ff, 28'b0};
         q_ff   <= '0;
      end else if (cmd.root_add) begin
         part_ff <= q2p_ff + qps_ff;
      end else if (cmd.root_step) begin
         ps_ff <= ps_ff >> 2;
         if (fits) begin
            q2p_ff <= trial;
            qps_ff <= (qps_ff >> 1) + ps_ff;
            q_ff   <= q_ff | (15'd1 << cmd.root_bit);
         end else begin
            qps_ff <= qps_ff >> 1;
         end
      end
   end

   // ---- output register ----
   logic [15:0] corr;
   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff;
   logic [1:0]  rsp_user_ff;

   always_comb begin
      if (code != pcorr_pkg::RES_OK) corr = '0;
      else if (num[63])              corr = -{1'b0, q_ff};
      else                           corr = {1'b0, q_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         rsp_data_ff <= {3'b0, count_ff, corr};
         rsp_user_ff <= code;
      end
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;
   assign rsp_tuser       = rsp_user_ff;
   assign status.mul_done = mul_done;
   assign status.code_ok  = (code == pcorr_pkg::RES_OK);
   assign status.out_free = !rsp_valid_ff || rsp_tready;

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for pearson_correlation_unit: streams x/y vector pairs,
// predicts r in Q1.14, status and pair count. Depends on pcorr_pkg and the RTL.
module testbench;

   // one expected correlation result
   typedef struct {
      logic signed [15:0]      corr;
      pcorr_pkg::res_code_type code;
      logic [12:0]             count;
   } corr_result_type;

   // Keeps its own copy of the sums and holds expected correlation results.
   class corr_scoreboard;
      longint        pairs;
      longint signed sx, sy, sxy, sxx, syy;
      bit            overflowed;
      corr_result_type pending[$];
      int            errors;
      int            results_seen;

      function void clear_sums();
         pairs = 0; sx = 0; sy = 0; sxy = 0; sxx = 0; syy = 0;
         overflowed = 0;
      endfunction

      // exact root search: largest q <= 16384 with q^2*vx*vy <= num^2*2^28
      function automatic logic [14:0] root_search(logic [255:0] num_mag,
                                                  logic [255:0] vx, logic [255:0] vy);
         logic [255:0] prod, rhs, c;
         logic [14:0] q;
         q = 0;
         prod = vx * vy;
         rhs = (num_mag * num_mag) << 28;
         for (int b = 14; b >= 0; b--) begin
            c = q | (15'd1 << b);
            if (c <= 16384 && c * c * prod <= rhs) q = c[14:0];
         end
         return q;
      endfunction

      // note one accepted request
      function void note_request(logic signed [15:0] x, logic signed [15:0] y, bit last);
         longint signed n, num, vx, vy;
         corr_result_type r;
         logic [14:0] q;
         if (pairs < 4096) begin
            pairs++;
            sx += x; sy += y;
            sxy += x * y; sxx += x * x; syy += y * y;
         end else begin
            overflowed = 1;
         end
         if (!last) return;
         n = pairs;
         num = n * sxy - sx * sy;
         vx = n * sxx - sx * sx;
         vy = n * syy - sy * sy;
         r.corr = 0;
         if (overflowed) r.code = pcorr_pkg::RES_OVERFLOW;
         else if (n < 2) r.code = pcorr_pkg::RES_SHORT;
         else if (vx == 0 || vy == 0) r.code = pcorr_pkg::RES_FLAT;
         else begin
            r.code = pcorr_pkg::RES_OK;
            q = root_search(num < 0 ? -num : num, vx, vy);
            r.corr = num < 0 ? -$signed({1'b0, q}) : $signed({1'b0, q});
         end
         r.count = n[12:0];
         pending.push_back(r);
         clear_sums();
      endfunction

      // check one accepted result against the oldest expectation
      function void check_result(logic [31:0] data, logic [1:0] code);
         corr_result_type e;
         results_seen++;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result data=%h status=%0d", $time, data, code);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (data[15:0] !== e.corr) begin
            $display("%0t: correlation expected %0d actual %0d", $time, e.corr,
                     $signed(data[15:0]));
            errors++;
         end
         if (code !== e.code) begin
            $display("%0t: status expected %0d actual %0d", $time, e.code, code);
            errors++;
         end
         if (data[28:16] !== e.count) begin
            $display("%0t: pair count expected %0d actual %0d", $time, e.count,
                     data[28:16]);
            errors++;
         end
         if (data[31:29] !== 3'd0) begin
            $display("%0t: padding expected 0 actual %h", $time, data[31:29]);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [31:0] req_tdata = 0;
   logic        req_tlast = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   pearson_correlation_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   corr_scoreboard board = new();

   int  send_idle_pct = 0;   // sender gap odds, percent
   int  recv_idle_pct = 0;   // receiver stall odds, percent
   bit  recv_hold = 0;       // long receiver hold-off
   int  requests_sent = 0;
   int  vectors_sent = 0;
   longint idle_cycles = 0;

   // receiver: random stalls, or a long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         rsp_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // monitor: note requests and check results at the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            board.note_request(req_tdata[15:0], req_tdata[31:16], req_tlast);
         if (rsp_tvalid && rsp_tready)
            board.check_result(rsp_tdata, rsp_tuser);
      end
   end

   // watchdog: cycles with no handshake on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("watchdog timeout");
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // offer one request and hold it until accepted; random gap before it
   task automatic send_pair(logic signed [15:0] x, logic signed [15:0] y, bit last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {y, x};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      requests_sent++;
      if (last) vectors_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   // random sample: full range, small or mid-size values, or extremes
   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(3))
         0: return 16'($urandom);
         1: return 16'($signed(16'($urandom_range(511))) - 256);
         2: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
         default: return 16'($signed(16'($urandom_range(8191))) - 4096);
      endcase
   endfunction

   // one vector pair; shape picks correlated, anti, constant or random data
   task automatic send_vector(int len);
      int shape;
      int gain;
      logic signed [15:0] x, y;
      shape = $urandom_range(5);
      gain = $urandom_range(1, 3);
      for (int i = 0; i < len; i++) begin
         x = pick_sample();
         case (shape)
            0: y = 16'(x / gain);
            1: y = 16'(-(x / gain));
            2: y = 16'sd77;
            3: y = 16'((x / 2) + $signed(16'($urandom_range(63))) - 32);
            default: y = pick_sample();
         endcase
         send_pair(x, y, i == len - 1);
      end
   endtask

   int len;

   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;

      // directed: single pair, two pairs, extremes, flat data, longer mixed vectors
      send_pair(16'sh7fff, 16'sh8000, 1);
      send_pair(16'sh8000, 16'sh8000, 0);
      send_pair(16'sh7fff, 16'sh7fff, 1);          // perfect positive
      send_pair(16'sh8000, 16'sh7fff, 0);
      send_pair(16'sh7fff, 16'sh8000, 1);          // perfect negative
      send_pair(16'sh0005, 16'sh0001, 0);
      send_pair(16'sh0005, 16'sh0009, 0);
      send_pair(16'sh0005, 16'sh0003, 1);          // x constant: zero variance
      send_pair(16'sh0001, 16'sh0002, 0);
      send_pair(16'sh0003, 16'sh0002, 1);          // y constant
      send_pair(16'sh0001, 16'sh0002, 0);
      send_pair(16'shffff, 16'sh0007, 0);
      send_pair(16'sh0004, 16'shfff0, 1);
      send_pair(16'sh8000, 16'sh8000, 0);
      send_pair(16'sh8000, 16'sh7fff, 0);
      send_pair(16'sh7fff, 16'sh8000, 0);
      send_pair(16'sh5555, 16'shaaaa, 1);
      drain();

      // random vectors in three idling phases
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = phase == 0 ? 38 : (phase == 1 ? 50 : 0);
         recv_idle_pct = phase == 0 ? 50 : (phase == 1 ? 38 : 0);
         for (int k = 0; k < 53; k++) begin
            len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 24);
            send_vector(len);
         end
         if (phase == 1) begin
            // long receiver hold-off while short vectors keep coming
            recv_hold = 1;
            fork
               begin
                  for (int k = 0; k < 6; k++) send_vector($urandom_range(2, 4));
               end
               begin
                  repeat (600) @(posedge clock);
                  recv_hold = 0;
               end
            join
         end
         drain();
      end

      repeat (100) @(posedge clock);
      $display("sent %0d requests in %0d vectors, checked %0d results", requests_sent,
               vectors_sent, board.results_seen);
      $display("covered extremes, single-pair and flat vectors, stalls and gaps");
      if (board.errors == 0 && board.pending.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule
